>>> rtl/akscan_pkg.sv
// ----------------------------------------------------------------------------
// akscan_pkg: shared types and constants of the ADC ladder key scanner
// Holds the key codes, register indexes, the window size and the structs
// that link the top level to the key tracker.
// ----------------------------------------------------------------------------
package akscan_pkg;

  // Window of ADC samples, one per cell
  localparam int unsigned WINDOW_DEPTH = 16;
  localparam int unsigned CNT_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  // Time none must be seen before the active key lets go
  localparam logic [31:0] RELEASE_MS = 32'd30;

  localparam logic [15:0] LEVEL_MAX = 16'hFFFF;

  // Item kinds
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_SCAN   = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_PRESS_TH = 3'd0;
  localparam logic [2:0] REG_LEFT_TH  = 3'd1;
  localparam logic [2:0] REG_RIGHT_TH = 3'd2;
  localparam logic [2:0] REG_UP_TH    = 3'd3;
  localparam logic [2:0] REG_DOWN_TH  = 3'd4;
  localparam logic [2:0] REG_ACT_MS   = 3'd5;
  localparam logic [2:0] REG_LONG_MS  = 3'd6;
  localparam logic [2:0] REG_REP_MS   = 3'd7;

  typedef enum logic [2:0] {
    KEY_NONE  = 3'd0,
    KEY_PRESS = 3'd1,
    KEY_LEFT  = 3'd2,
    KEY_RIGHT = 3'd3,
    KEY_UP    = 3'd4,
    KEY_DOWN  = 3'd5
  } key_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECODE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [15:0] press_th;
    logic [15:0] left_th;
    logic [15:0] right_th;
    logic [15:0] up_th;
    logic [15:0] down_th;
    logic [15:0] activate_ms;
    logic [15:0] longpress_ms;
    logic [15:0] repeat_ms;
  } cfg_t;

  // Strobes from the sequencer to the key tracker
  typedef struct packed {
    logic decode;
    logic update;
  } ctrl_t;

  // One result of a scan
  typedef struct packed {
    key_t        stable_key;
    logic [15:0] filtered_adc;
    logic        event_valid;
    key_t        event_key;
  } result_t;

  // Threshold ladder, first match wins
  function automatic key_t decode_level(input logic [15:0] v, input cfg_t c);
    key_t k;
    if (v <= c.press_th) begin
      k = KEY_PRESS;
    end else if (v <= c.left_th) begin
      k = KEY_LEFT;
    end else if (v <= c.right_th) begin
      k = KEY_RIGHT;
    end else if (v <= c.up_th) begin
      k = KEY_UP;
    end else if (v <= c.down_th) begin
      k = KEY_DOWN;
    end else begin
      k = KEY_NONE;
    end
    return k;
  endfunction

endpackage

>>> rtl/akscan_cell.sv
// ----------------------------------------------------------------------------
// akscan_cell: one slot of the sample window
// Holds one sample, shifts it on to the next cell when a new sample enters,
// and folds its sample into the running minimum that walks down the row.
// ----------------------------------------------------------------------------
module akscan_cell (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        shift_en,
  input  logic [15:0] sample_in,
  input  logic [15:0] min_in,
  output logic [15:0] sample_out,
  output logic [15:0] min_out
);
  import akscan_pkg::*;

  logic [15:0] sample_r;
  logic [15:0] min_r;
  logic [15:0] min_nxt;

  // Running minimum moves one cell per cycle
  assign min_nxt = (min_in < sample_r) ? min_in : sample_r;

  // Window slots start at full scale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= LEVEL_MAX;
    end else if (shift_en) begin
      sample_r <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
  end

  assign sample_out = sample_r;
  assign min_out    = min_r;

endmodule

>>> rtl/akscan_keyfsm.sv
// ----------------------------------------------------------------------------
// akscan_keyfsm: key debounce, release hold-off and auto-repeat
// Decode step registers the ladder key and the elapsed-time checks; the
// update step applies them to the key state and forms the scan result.
// ----------------------------------------------------------------------------
module akscan_keyfsm (
  input  logic                clk,
  input  logic                rst_n,
  input  akscan_pkg::ctrl_t   ctrl,
  input  akscan_pkg::cfg_t    cfg,
  input  logic [15:0]         level_in,
  input  logic [31:0]         now,
  output akscan_pkg::result_t res
);
  import akscan_pkg::*;

  // Key state
  key_t        cand_key_r, cand_key_nxt;
  logic [31:0] cand_since_r, cand_since_nxt;
  key_t        act_key_r, act_key_nxt;
  logic [31:0] act_since_r, act_since_nxt;
  logic [31:0] next_rep_r, next_rep_nxt;
  logic [31:0] rel_since_r, rel_since_nxt;
  logic        rel_pend_r, rel_pend_nxt;
  logic        long_act_r, long_act_nxt;

  // Decode step results
  logic [15:0] level_r;
  key_t        dec_r;
  logic        cand_ok_r, long_ok_r, rep_due_r, rel_ok_r;

  logic [31:0] cand_diff, act_diff, rep_diff, rel_diff;
  logic        is_dir;
  logic        ev;
  key_t        ev_key, held;

  // Wrapping elapsed times
  assign cand_diff = now - cand_since_r;
  assign act_diff  = now - act_since_r;
  assign rep_diff  = now - next_rep_r;
  assign rel_diff  = now - rel_since_r;

  always_ff @(posedge clk) begin
    if (ctrl.decode) begin
      level_r   <= level_in;
      dec_r     <= decode_level(level_in, cfg);
      cand_ok_r <= cand_diff >= {16'd0, cfg.activate_ms};
      long_ok_r <= act_diff >= {16'd0, cfg.longpress_ms};
      rep_due_r <= !rep_diff[31];
      // A release that starts at this scan has zero elapsed time
      rel_ok_r  <= rel_pend_r ? (rel_diff >= RELEASE_MS) : (RELEASE_MS == 32'd0);
    end
  end

  assign is_dir = (act_key_r == KEY_LEFT) || (act_key_r == KEY_RIGHT) ||
                  (act_key_r == KEY_UP) || (act_key_r == KEY_DOWN);

  // Update step
  always_comb begin
    cand_key_nxt   = cand_key_r;
    cand_since_nxt = cand_since_r;
    act_key_nxt    = act_key_r;
    act_since_nxt  = act_since_r;
    next_rep_nxt   = next_rep_r;
    rel_since_nxt  = rel_since_r;
    rel_pend_nxt   = rel_pend_r;
    long_act_nxt   = long_act_r;
    ev             = 1'b0;
    ev_key         = KEY_NONE;
    held           = KEY_NONE;
    if (act_key_r == KEY_NONE) begin
      if (dec_r != cand_key_r) begin
        cand_key_nxt   = dec_r;
        cand_since_nxt = now;
      end else if (cand_key_r != KEY_NONE && cand_ok_r) begin
        act_key_nxt   = cand_key_r;
        act_since_nxt = now;
        next_rep_nxt  = now + {16'd0, cfg.longpress_ms};
        rel_pend_nxt  = 1'b0;
        long_act_nxt  = 1'b0;
        held          = cand_key_r;
        ev            = 1'b1;
        ev_key        = cand_key_r;
      end
    end else begin
      held = act_key_r;
      if (dec_r == KEY_NONE) begin
        if (!rel_pend_r) begin
          rel_pend_nxt  = 1'b1;
          rel_since_nxt = now;
        end
        if (rel_ok_r) begin
          act_key_nxt    = KEY_NONE;
          cand_key_nxt   = KEY_NONE;
          cand_since_nxt = now;
          rel_pend_nxt   = 1'b0;
          long_act_nxt   = 1'b0;
          held           = KEY_NONE;
        end
      end else begin
        rel_pend_nxt = 1'b0;
        if (is_dir) begin
          if (!long_act_r) begin
            if (long_ok_r) begin
              long_act_nxt = 1'b1;
              next_rep_nxt = now + {16'd0, cfg.repeat_ms};
              ev           = 1'b1;
              ev_key       = act_key_r;
            end
          end else if (rep_due_r) begin
            next_rep_nxt = now + {16'd0, cfg.repeat_ms};
            ev           = 1'b1;
            ev_key       = act_key_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_key_r   <= KEY_NONE;
      cand_since_r <= '0;
      act_key_r    <= KEY_NONE;
      act_since_r  <= '0;
      next_rep_r   <= '0;
      rel_since_r  <= '0;
      rel_pend_r   <= 1'b0;
      long_act_r   <= 1'b0;
    end else if (ctrl.update) begin
      cand_key_r   <= cand_key_nxt;
      cand_since_r <= cand_since_nxt;
      act_key_r    <= act_key_nxt;
      act_since_r  <= act_since_nxt;
      next_rep_r   <= next_rep_nxt;
      rel_since_r  <= rel_since_nxt;
      rel_pend_r   <= rel_pend_nxt;
      long_act_r   <= long_act_nxt;
    end
  end

  assign res.stable_key   = held;
  assign res.filtered_adc = level_r;
  assign res.event_valid  = ev;
  assign res.event_key    = ev_key;

endmodule

>>> rtl/adc_ladder_key_scanner.sv
// ----------------------------------------------------------------------------
// adc_ladder_key_scanner: resistor ladder key scanner
// Sample window as a row of cells, minimum walk, threshold decode, debounce,
// release hold-off and auto-repeat of direction keys.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   in       | in_valid/in_stall  | operation, sample, now_ms
//   out      | out_valid/out_stall| stable_key, filtered_adc, event_valid,
//            |                    | event_key
//   cfg      | APB psel/penable   | 8 x 16-bit registers at 4*index
//
// A sample item is taken and shifts into the cell row.
// A scan item is taken, then the running minimum walks the whole cell
// row, then one step decodes the level and one step updates the key
// state.
// in_stall is high from a scan's acceptance until its result is registered;
// a full output register that is stalled holds the update step.
// Synchronous active-low reset fills the window with full-scale samples.
// ----------------------------------------------------------------------------
module adc_ladder_key_scanner (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [15:0] in_sample,
  input  logic [31:0] in_now_ms,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_stable_key,
  output logic [15:0] out_filtered_adc,
  output logic        out_event_valid,
  output logic [2:0]  out_event_key,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import akscan_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic [31:0]      now_r;
  cfg_t             cfg_r;
  ctrl_t            ctrl;
  result_t          res;

  logic             in_acc, shift_en, scan_acc, out_free, cfg_wr;
  logic [2:0]       cfg_idx;
  logic [15:0]      cfg_rd;

  logic [15:0]      cell_sample [WINDOW_DEPTH];
  logic [15:0]      cell_min [WINDOW_DEPTH];

  logic             out_valid_r;
  key_t             out_stable_r, out_evkey_r;
  logic [15:0]      out_level_r;
  logic             out_ev_r;

  assign in_acc   = in_valid && !in_stall;
  assign shift_en = in_acc && (in_operation == OP_SAMPLE);
  assign scan_acc = in_acc && (in_operation == OP_SCAN);
  assign out_free = !out_valid_r || !out_stall;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_th     <= 16'd6553;
      cfg_r.left_th      <= 16'd19660;
      cfg_r.right_th     <= 16'd32767;
      cfg_r.up_th        <= 16'd45874;
      cfg_r.down_th      <= 16'd58981;
      cfg_r.activate_ms  <= 16'd40;
      cfg_r.longpress_ms <= 16'd600;
      cfg_r.repeat_ms    <= 16'd120;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PRESS_TH: cfg_r.press_th     <= cfg_pwdata[15:0];
        REG_LEFT_TH:  cfg_r.left_th      <= cfg_pwdata[15:0];
        REG_RIGHT_TH: cfg_r.right_th     <= cfg_pwdata[15:0];
        REG_UP_TH:    cfg_r.up_th        <= cfg_pwdata[15:0];
        REG_DOWN_TH:  cfg_r.down_th      <= cfg_pwdata[15:0];
        REG_ACT_MS:   cfg_r.activate_ms  <= cfg_pwdata[15:0];
        REG_LONG_MS:  cfg_r.longpress_ms <= cfg_pwdata[15:0];
        REG_REP_MS:   cfg_r.repeat_ms    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PRESS_TH: cfg_rd = cfg_r.press_th;
      REG_LEFT_TH:  cfg_rd = cfg_r.left_th;
      REG_RIGHT_TH: cfg_rd = cfg_r.right_th;
      REG_UP_TH:    cfg_rd = cfg_r.up_th;
      REG_DOWN_TH:  cfg_rd = cfg_r.down_th;
      REG_ACT_MS:   cfg_rd = cfg_r.activate_ms;
      REG_LONG_MS:  cfg_rd = cfg_r.longpress_ms;
      REG_REP_MS:   cfg_rd = cfg_r.repeat_ms;
      default:      cfg_rd = '0;
    endcase
  end
  assign cfg_prdata = {16'd0, cfg_rd};

  // Cell row: samples shift toward the end, the minimum walks the same way
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic [15:0] s_in, m_in;
    if (i == 0) begin : g_head
      assign s_in = in_sample;
      assign m_in = LEVEL_MAX;
    end else begin : g_body
      assign s_in = cell_sample[i-1];
      assign m_in = cell_min[i-1];
    end
    akscan_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (shift_en),
      .sample_in  (s_in),
      .min_in     (m_in),
      .sample_out (cell_sample[i]),
      .min_out    (cell_min[i])
    );
  end

  // Scan timestamp
  always_ff @(posedge clk) begin
    if (scan_acc) begin
      now_r <= in_now_ms;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        scan_cnt_nxt = '0;
        if (scan_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == CNT_W'(WINDOW_DEPTH - 1)) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall    = 1'b1;
    ctrl.decode = 1'b0;
    ctrl.update = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall    = 1'b0;
      ST_SCAN:   ;
      ST_DECODE: ctrl.decode = 1'b1;
      ST_UPDATE: ctrl.update = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
    end
  end

  akscan_keyfsm u_keyfsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .cfg      (cfg_r),
    .level_in (cell_min[WINDOW_DEPTH-1]),
    .now      (now_r),
    .res      (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.update) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      out_stable_r <= res.stable_key;
      out_level_r  <= res.filtered_adc;
      out_ev_r     <= res.event_valid;
      out_evkey_r  <= res.event_key;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_stable_key   = out_stable_r;
  assign out_filtered_adc = out_level_r;
  assign out_event_valid  = out_ev_r;
  assign out_event_key    = out_evkey_r;

  // A new result appears only from the update step
  a_out_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPDATE))
    else $error("result appeared outside the update step");

  // Decode only after the minimum walked the whole row
  a_full_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECODE) |->
      ($past(state_r == ST_SCAN) && $past(scan_cnt_r) == CNT_W'(WINDOW_DEPTH - 1)))
    else $error("decode started before the minimum walk finished");

  // No event means no event key
  a_ev_key_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ev_r) |-> (out_evkey_r == KEY_NONE))
    else $error("event key set without an event");

  // An event always names the stable key
  a_ev_is_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r) |-> (out_evkey_r == out_stable_r))
    else $error("event key differs from stable key");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ADC ladder key scanner
// Drives sample and scan items with random gaps against a random result
// stall. A key tracker in the bench predicts every scan result, which the
// monitor checks field by field. Runs through several register settings,
// the extremes among them, rewriting the registers only while the block is
// idle.
// ----------------------------------------------------------------------------
module tb_top;
  import akscan_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int SETTLE_CYCLES = 2 * (WINDOW_DEPTH + 3) + 10;
  localparam int QUIET_LIMIT   = 4000;

  typedef struct packed {
    logic        op;
    logic [15:0] sample;
    logic [31:0] now_ms;
  } kbd_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = OP_SAMPLE;
  logic [15:0] in_sample = '0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_stable_key;
  logic [15:0] out_filtered_adc;
  logic        out_event_valid;
  logic [2:0]  out_event_key;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  adc_ladder_key_scanner DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_sample       (in_sample),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_stable_key  (out_stable_key),
    .out_filtered_adc(out_filtered_adc),
    .out_event_valid (out_event_valid),
    .out_event_key   (out_event_key),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Items waiting for the driver, scan results waiting for the monitor
  kbd_item_t pending_items[$];
  result_t   expected_reports[$];
  int        mismatches = 0;
  int        queued_count = 0;
  logic [31:0] stamp_ms;

  // Register copy held by the key tracker
  logic [15:0] ladder_th[0:4];
  logic [15:0] act_ms, long_ms, rep_ms;

  // Key tracker state
  logic [15:0] win[0:WINDOW_DEPTH-1];
  int          wpos;
  key_t        cand_key, act_key, held_key;
  logic [31:0] cand_since, act_since, next_rep, rel_since;
  bit          rel_pending, long_on;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Key tracker: window minimum, threshold ladder, debounce, release, repeat
  // --------------------------------------------------------------------------
  task automatic tracker_reset();
    ladder_th[0] = 16'd6553;
    ladder_th[1] = 16'd19660;
    ladder_th[2] = 16'd32767;
    ladder_th[3] = 16'd45874;
    ladder_th[4] = 16'd58981;
    act_ms  = 16'd40;
    long_ms = 16'd600;
    rep_ms  = 16'd120;
    for (int i = 0; i < WINDOW_DEPTH; i++) win[i] = LEVEL_MAX;
    wpos = 0;
    cand_key = KEY_NONE;
    act_key  = KEY_NONE;
    held_key = KEY_NONE;
    cand_since = '0;
    act_since  = '0;
    next_rep   = '0;
    rel_since  = '0;
    rel_pending = 1'b0;
    long_on     = 1'b0;
  endtask

  task automatic track_keys(input kbd_item_t it);
    logic [15:0] level;
    logic [31:0] now;
    logic [31:0] late;
    key_t        seen;
    result_t     res;
    if (it.op == OP_SAMPLE) begin
      win[wpos] = it.sample;
      wpos = (wpos + 1) % WINDOW_DEPTH;
    end else begin
      now = it.now_ms;
      level = LEVEL_MAX;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        if (win[i] < level) level = win[i];
      end
      // first matching threshold wins, even when the ladder is unordered
      if (level <= ladder_th[0]) seen = KEY_PRESS;
      else if (level <= ladder_th[1]) seen = KEY_LEFT;
      else if (level <= ladder_th[2]) seen = KEY_RIGHT;
      else if (level <= ladder_th[3]) seen = KEY_UP;
      else if (level <= ladder_th[4]) seen = KEY_DOWN;
      else seen = KEY_NONE;
      res.event_valid = 1'b0;
      res.event_key   = KEY_NONE;
      if (act_key == KEY_NONE) begin
        // debounce the candidate
        if (seen != cand_key) begin
          cand_key = seen;
          cand_since = now;
        end else if (cand_key != KEY_NONE && (now - cand_since) >= {16'h0, act_ms}) begin
          act_key = cand_key;
          act_since = now;
          next_rep = now + {16'h0, long_ms};
          rel_pending = 1'b0;
          long_on = 1'b0;
          held_key = act_key;
          res.event_valid = 1'b1;
          res.event_key = act_key;
        end else begin
          held_key = KEY_NONE;
        end
      end else begin
        held_key = act_key;
        if (seen == KEY_NONE) begin
          // release once none has lasted the release time
          if (!rel_pending) begin
            rel_pending = 1'b1;
            rel_since = now;
          end
          if ((now - rel_since) >= RELEASE_MS) begin
            act_key = KEY_NONE;
            cand_key = KEY_NONE;
            cand_since = now;
            rel_pending = 1'b0;
            long_on = 1'b0;
            held_key = KEY_NONE;
          end
        end else begin
          // any key, even another one, cancels a pending release
          rel_pending = 1'b0;
          if (act_key != KEY_PRESS) begin
            late = now - next_rep;
            if (!long_on) begin
              if ((now - act_since) >= {16'h0, long_ms}) begin
                long_on = 1'b1;
                next_rep = now + {16'h0, rep_ms};
                res.event_valid = 1'b1;
                res.event_key = act_key;
              end
            end else if (!late[31]) begin
              next_rep = now + {16'h0, rep_ms};
              res.event_valid = 1'b1;
              res.event_key = act_key;
            end
          end
        end
      end
      res.stable_key = held_key;
      res.filtered_adc = level;
      expected_reports.push_back(res);
    end
  endtask

  // --------------------------------------------------------------------------
  // Idle lengths: mostly none or short, a few long
  // --------------------------------------------------------------------------
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: drives items from the pending queue, predicts on each accepted item
  // --------------------------------------------------------------------------
  kbd_item_t on_bus;
  int        gap_left = 0;
  int        in_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) track_keys(on_bus);
      if (in_calm > 0) in_calm <= in_calm - 1;
      else if ($urandom_range(0, 399) == 0) in_calm <= 200;
      if (!in_valid || !in_stall) begin
        if (gap_left == 0 && pending_items.size() != 0) begin
          on_bus = pending_items.pop_front();
          in_valid     <= 1'b1;
          in_operation <= on_bus.op;
          in_sample    <= on_bus.sample;
          in_now_ms    <= on_bus.now_ms;
          gap_left     <= (in_calm > 0) ? 0 : pick_idle();
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result stall: random bursts with calm stretches
  // --------------------------------------------------------------------------
  int stall_left = 0;
  int out_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_calm > 0) out_calm <= out_calm - 1;
      else if ($urandom_range(0, 499) == 0) out_calm <= 300;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        if (out_calm == 0 && $urandom_range(0, 2) == 0) stall_left <= pick_idle();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each accepted result against the oldest expectation
  // --------------------------------------------------------------------------
  result_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected result key=%0d adc=%0h ev=%0b/%0d",
          out_stable_key, out_filtered_adc, out_event_valid, out_event_key));
      end else begin
        want = expected_reports.pop_front();
        if (out_stable_key !== want.stable_key)
          report_mismatch($sformatf("stable_key got %0d want %0d",
            out_stable_key, want.stable_key));
        if (out_filtered_adc !== want.filtered_adc)
          report_mismatch($sformatf("filtered_adc got %0h want %0h",
            out_filtered_adc, want.filtered_adc));
        if (out_event_valid !== want.event_valid)
          report_mismatch($sformatf("event_valid got %0b want %0b",
            out_event_valid, want.event_valid));
        if (out_event_key !== want.event_key)
          report_mismatch($sformatf("event_key got %0d want %0d",
            out_event_key, want.event_key));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with no item, result or register write
  // --------------------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register writes and item builders
  // --------------------------------------------------------------------------
  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'h0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx) inside
      REG_PRESS_TH, REG_LEFT_TH, REG_RIGHT_TH, REG_UP_TH, REG_DOWN_TH: ladder_th[idx] = val;
      REG_ACT_MS:  act_ms = val;
      REG_LONG_MS: long_ms = val;
      REG_REP_MS:  rep_ms = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] th[0:4], input logic [15:0] a,
                           input logic [15:0] l, input logic [15:0] r);
    cfg_write(REG_PRESS_TH, th[0]);
    cfg_write(REG_LEFT_TH, th[1]);
    cfg_write(REG_RIGHT_TH, th[2]);
    cfg_write(REG_UP_TH, th[3]);
    cfg_write(REG_DOWN_TH, th[4]);
    cfg_write(REG_ACT_MS, a);
    cfg_write(REG_LONG_MS, l);
    cfg_write(REG_REP_MS, r);
  endtask

  // random ladder, sorted into order unless asked otherwise
  task automatic random_ladder(input bit ordered, output logic [15:0] th[0:4]);
    logic [15:0] t;
    for (int i = 0; i < 5; i++) th[i] = 16'($urandom_range(0, 65535));
    if (ordered) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4 - i; j++) begin
          if (th[j] > th[j + 1]) begin
            t = th[j];
            th[j] = th[j + 1];
            th[j + 1] = t;
          end
        end
      end
    end
  endtask

  // waits until nothing is in flight, then for the block to drain
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_sample(input logic [15:0] s);
    kbd_item_t it;
    it.op = OP_SAMPLE;
    it.sample = s;
    it.now_ms = $urandom;
    pending_items.push_back(it);
    queued_count++;
  endtask

  task automatic push_scan(input logic [31:0] dt);
    kbd_item_t it;
    stamp_ms = stamp_ms + dt;
    it.op = OP_SCAN;
    it.sample = 16'($urandom_range(0, 65535));
    it.now_ms = stamp_ms;
    pending_items.push_back(it);
    queued_count++;
  endtask

  // a level that decodes as the given key under the current ladder, when the
  // ladder is in order and leaves room for one
  function automatic logic [15:0] level_for(input key_t k);
    int lo, hi;
    if (k == KEY_NONE) begin
      lo = int'(ladder_th[4]) + 1;
      hi = 65535;
    end else begin
      lo = (k == KEY_PRESS) ? 0 : int'(ladder_th[int'(k) - 2]) + 1;
      hi = int'(ladder_th[int'(k) - 1]);
    end
    if (lo > hi) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic logic [31:0] pick_step(input int dt_max);
    if ($urandom_range(0, 99) < 3) return $urandom;
    return $urandom_range(0, dt_max);
  endfunction

  // --------------------------------------------------------------------------
  // One key stroke: let go, press, hold for a while with some noise, or raw noise
  // --------------------------------------------------------------------------
  task automatic key_stroke(input int dt_max);
    key_t        k;
    int          r, n, held;
    logic [31:0] dt;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // raw noise items
      n = $urandom_range(5, 20);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1) == 0) push_sample(16'($urandom_range(0, 65535)));
        else push_scan(pick_step(dt_max));
      end
    end else begin
      k = key_t'(3'($urandom_range(1, 5)));
      for (int i = 0; i < WINDOW_DEPTH; i++) push_sample(level_for(KEY_NONE));
      if (r < 25) begin
        // short glitch of none, may not release
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) push_scan($urandom_range(0, dt_max));
      end else begin
        held = 0;
        n = 0;
        while (held < int'(RELEASE_MS) + 10 && n < 40) begin
          dt = $urandom_range(1, dt_max + 1);
          push_scan(dt);
          held += int'(dt);
          n++;
        end
      end
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) push_sample(level_for(k));
      r = $urandom_range(0, 99);
      n = (r < 50) ? $urandom_range(1, 15) : (r < 90) ? $urandom_range(16, 60)
                                                      : $urandom_range(61, 100);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 10) push_sample(level_for(k));
        else if (r < 14) push_sample(level_for(key_t'(3'($urandom_range(0, 5)))));
        push_scan(pick_step(dt_max));
      end
    end
  endtask

  task automatic run_phase(input int n_items, input int dt_max);
    int start;
    start = queued_count;
    while (queued_count - start < n_items) key_stroke(dt_max);
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [15:0] th[0:4];

  initial begin
    tracker_reset();
    stamp_ms = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes of the fields at reset settings
    push_scan(32'h0 - stamp_ms);           // full-scale window reads none at time 0
    push_sample(16'hFFFF);
    push_sample(16'h0000);                 // lowest level, press
    push_scan(32'hFFFF_FFF0);              // candidate starts just before the wrap
    push_scan(32'h20);                     // 32 ms across the wrap, not yet
    push_scan(32'h10);                     // 48 ms, press becomes active
    push_scan(32'h7FFF_FFFF);              // press held very long never repeats
    for (int i = 0; i < WINDOW_DEPTH; i++) push_sample(16'hFFFF);
    push_scan(32'd5);                      // none starts the release time
    push_scan(RELEASE_MS);                 // released
    settle();

    // reset settings, coarse time steps
    run_phase(150, 40);

    // short timing, default ladder
    th = ladder_th;
    write_all(th, 16'd5, 16'd60, 16'd10);
    run_phase(150, 8);

    // zero hold times, fastest repeat, across the timestamp wrap
    random_ladder(1'b1, th);
    write_all(th, 16'd0, 16'd0, 16'd1);
    stamp_ms = 32'hFFFF_FF00;
    run_phase(140, 3);

    // ladder all zero, longest times
    for (int i = 0; i < 5; i++) th[i] = 16'h0000;
    write_all(th, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(140, 20000);

    // ladder all full scale: everything reads as press
    for (int i = 0; i < 5; i++) th[i] = 16'hFFFF;
    write_all(th, 16'd10, 16'd100, 16'd20);
    run_phase(120, 15);

    // unordered ladder
    random_ladder(1'b0, th);
    write_all(th, 16'($urandom_range(0, 30)), 16'($urandom_range(0, 200)),
              16'($urandom_range(1, 40)));
    run_phase(140, 20);

    // random ordered ladder, random timing
    random_ladder(1'b1, th);
    write_all(th, 16'($urandom_range(0, 300)), 16'($urandom_range(0, 1000)),
              16'($urandom_range(1, 200)));
    run_phase(160, 60);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/akscan_pkg.sv
rtl/akscan_cell.sv
rtl/akscan_keyfsm.sv
rtl/adc_ladder_key_scanner.sv
bench/tb_top.sv
